// File: hw/rtl/hklp_pkg.sv
package hklp_pkg;

    localparam int TableBits = 10;
    localparam int TableSize = 1 << TableBits;
    localparam int CountBits = 11;

    localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
    localparam logic [63:0] FnvPrime = 64'h00000100000001b3;
    localparam logic [63:0] AllOnes  = 64'hFFFFFFFFFFFFFFFF;

    localparam logic [1:0] FuncLookup = 2'd0;
    localparam logic [1:0] FuncInsert = 2'd1;
    localparam logic [1:0] FuncDelete = 2'd2;

    localparam logic [1:0] StEmpty    = 2'd0;
    localparam logic [1:0] StOccupied = 2'd1;
    localparam logic [1:0] StDeleted  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  key_byte;
        logic        byte_valid;
        logic        key_last;
        logic [63:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic                 success;
        logic [63:0]          found_value;
        logic [CountBits-1:0] live_entries;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hash_mul;     // multiply the xor-ed hash by the prime
        logic hash_xor;     // load hash register with hash ^ byte (or hold)
        logic take_op;      // latch key hash, home index, reset hash
        logic clr_step;     // clear one slot during the clearing pass
        logic load_item;    // latch op and new value of the last transfer
        logic advance;      // step probe index and probe count
        logic note_free;    // remember probe slot as first free
        logic wr_hit;       // write probe slot (update / delete)
        logic wr_free;      // write the remembered free slot as new entry
        logic inc_count;
        logic dec_count;
        logic emit;         // present a result
        logic res_success;
        logic res_value;    // found value comes from the slot read
        logic res_miss;     // found value is all ones
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clr_done;
        logic [1:0] rd_status;
        logic       hash_match;
        logic       have_free;
        logic       probe_done;  // all slots visited
        logic [1:0] func;
    } dp_stat_t;

endpackage

// File: hw/rtl/hashed_key_linear_probe_map.sv
// Hashed-key map with linear probing. Key bytes arrive one per transfer
// (start high while busy is low) and fold into a 64-bit FNV-1a hash; the
// transfer with key_last runs a lookup, insert or delete against a table of
// 1024 slots held in block RAM. A byte with byte_valid is folded in by an
// xor, then one 64-bit constant multiply; a last item then latches the
// hash and visits each probed slot in a read state and a check state, as
// the RAM read of each slot is registered. Exactly one result comes per
// key_last transfer, registered and on result for one cycle with
// result_valid high; the receiver cannot stall it, so it must take every
// result as it appears. After reset the block clears the status memory
// slot by slot while busy stays high. Slot hashes are compared in full, so
// two keys with the same hash are one key.
module hashed_key_linear_probe_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  hklp_pkg::in_item_t   item,
    output logic                 busy,
    output logic                 result_valid,
    output hklp_pkg::out_item_t  result
);

    hklp_pkg::dp_cmd_t  cmd;
    hklp_pkg::dp_stat_t stat;

    hklp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .byte_valid (item.byte_valid),
        .key_last   (item.key_last),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    hklp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef ASSERT_OFF
    // A result only appears while an operation is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an operation");

    // A lookup miss always returns all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.success && $past(cmd.res_miss))
            |-> result.found_value == hklp_pkg::AllOnes)
        else $error("lookup miss value wrong");

    // The count never moves by itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.inc_count && !cmd.dec_count) |=> $stable(u_dp.count_reg))
        else $error("count drift");
`endif

endmodule

// File: hw/rtl/hklp_ram.sv
module hklp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/hklp_datapath.sv
module hklp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hklp_pkg::in_item_t   item,
    input  hklp_pkg::dp_cmd_t    cmd,
    output hklp_pkg::dp_stat_t   stat,
    output hklp_pkg::out_item_t  result,
    output logic                 result_valid
);

    localparam int Tb = hklp_pkg::TableBits;
    localparam int Cb = hklp_pkg::CountBits;

    logic [63:0]   hash_reg, hash_next;
    logic [63:0]   key_hash_reg;
    logic [1:0]    func_reg;
    logic [63:0]   nval_reg;
    logic [Tb-1:0] idx_reg;
    logic [Tb:0]   cnt_reg;
    logic [Tb-1:0] free_reg;
    logic          have_free_reg;
    logic [Tb:0]   clr_reg;
    logic [Cb-1:0] count_reg;
    logic          rv_reg;
    hklp_pkg::out_item_t res_reg;

    logic [1:0]    st_rd;
    logic [63:0]   hash_rd, val_rd;
    logic          st_we, hv_we;
    logic [Tb-1:0] waddr;
    logic [1:0]    st_wd;
    logic [63:0]   val_wd;

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.take_op)
        begin
            hash_next = hklp_pkg::FnvBasis;
        end
        else if (cmd.hash_mul)
        begin
            // The FNV prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0, so the
            // multiply is a sum of shifted copies of the hash.
            hash_next = (hash_reg << 40) + (hash_reg << 8) + (hash_reg << 7)
                      + (hash_reg << 5) + (hash_reg << 4) + (hash_reg << 1)
                      + hash_reg;
        end
        else if (cmd.hash_xor)
        begin
            hash_next = hash_reg ^ {56'd0, item.key_byte};
        end
    end

    always_comb
    begin
        st_we  = 1'b0;
        hv_we  = 1'b0;
        waddr  = idx_reg;
        st_wd  = hklp_pkg::StEmpty;
        val_wd = nval_reg;
        if (cmd.clr_step)
        begin
            st_we = 1'b1;
            waddr = clr_reg[Tb-1:0];
        end
        else if (cmd.wr_free)
        begin
            st_we = 1'b1;
            hv_we = 1'b1;
            // With no free slot noted yet, the empty probe slot is the first.
            waddr = have_free_reg ? free_reg : idx_reg;
            st_wd = hklp_pkg::StOccupied;
        end
        else if (cmd.wr_hit)
        begin
            hv_we = 1'b1;
            if (func_reg == hklp_pkg::FuncDelete)
            begin
                st_we  = 1'b1;
                st_wd  = hklp_pkg::StDeleted;
                val_wd = 64'd0;
            end
        end
    end

    hklp_ram #(.Width(2), .Depth(hklp_pkg::TableSize)) u_status (
        .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wd),
        .raddr(idx_reg), .rdata(st_rd)
    );

    hklp_ram #(.Width(64), .Depth(hklp_pkg::TableSize)) u_hash (
        .clk(clk), .we(hv_we & cmd.wr_free), .waddr(waddr), .wdata(key_hash_reg),
        .raddr(idx_reg), .rdata(hash_rd)
    );

    hklp_ram #(.Width(64), .Depth(hklp_pkg::TableSize)) u_value (
        .clk(clk), .we(hv_we), .waddr(waddr), .wdata(val_wd),
        .raddr(idx_reg), .rdata(val_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= hklp_pkg::FnvBasis;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            have_free_reg <= 1'b0;
            clr_reg       <= '0;
            count_reg     <= '0;
            rv_reg        <= 1'b0;
            func_reg      <= hklp_pkg::FuncLookup;
        end
        else
        begin
            hash_reg <= hash_next;
            rv_reg   <= cmd.emit;
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.load_item)
            begin
                func_reg <= item.func;
            end
            if (cmd.take_op)
            begin
                idx_reg       <= hash_reg[Tb-1:0];
                cnt_reg       <= '0;
                have_free_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.note_free)
            begin
                have_free_reg <= 1'b1;
            end
            if (cmd.inc_count)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_op)
        begin
            key_hash_reg <= hash_reg;
        end
        if (cmd.load_item)
        begin
            nval_reg <= item.new_value;
        end
        if (cmd.note_free)
        begin
            free_reg <= idx_reg;
        end
        if (cmd.emit)
        begin
            res_reg.success <= cmd.res_success;
            res_reg.found_value <= cmd.res_value ? val_rd :
                                   (cmd.res_miss ? hklp_pkg::AllOnes : 64'd0);
            // Count update lands the same edge; show the value after it.
            res_reg.live_entries <= cmd.inc_count ? count_reg + 1'b1 :
                                    (cmd.dec_count ? count_reg - 1'b1 : count_reg);
        end
    end

    assign stat.clr_done   = clr_reg[Tb];
    assign stat.rd_status  = st_rd;
    assign stat.hash_match = (hash_rd == key_hash_reg);
    assign stat.have_free  = have_free_reg;
    assign stat.probe_done = cnt_reg[Tb];
    assign stat.func       = func_reg;

    assign result       = res_reg;
    assign result_valid = rv_reg;

endmodule

// File: hw/rtl/hklp_ctrl.sv
module hklp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                byte_valid,
    input  logic                key_last,
    input  hklp_pkg::dp_stat_t  stat,
    output hklp_pkg::dp_cmd_t   cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   mul_last_reg, mul_last_next;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        mul_last_next = mul_last_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    // The operation and its value belong to the last transfer.
                    cmd.load_item = key_last;
                    if (byte_valid)
                    begin
                        cmd.hash_xor  = 1'b1;
                        mul_last_next = key_last;
                        state_next    = S_MUL;
                    end
                    else if (key_last)
                    begin
                        cmd.take_op = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_MUL:
            begin
                cmd.hash_mul = 1'b1;
                state_next   = mul_last_reg ? S_DONE : S_IDLE;
            end
            S_DONE:
            begin
                // Hash is final; capture it and start the probe.
                cmd.take_op = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                if (stat.func == hklp_pkg::FuncLookup || stat.func == hklp_pkg::FuncInsert
                    || stat.func == hklp_pkg::FuncDelete)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (stat.probe_done)
                begin
                    cmd.emit = 1'b1;
                    if (stat.func == hklp_pkg::FuncLookup)
                    begin
                        cmd.res_miss = 1'b1;
                    end
                    else if (stat.func == hklp_pkg::FuncInsert && stat.have_free)
                    begin
                        cmd.wr_free = 1'b1;
                        cmd.inc_count = 1'b1;
                        cmd.res_success = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (stat.rd_status == hklp_pkg::StEmpty)
                begin
                    cmd.emit = 1'b1;
                    if (stat.func == hklp_pkg::FuncLookup)
                    begin
                        cmd.res_miss = 1'b1;
                    end
                    else if (stat.func == hklp_pkg::FuncInsert)
                    begin
                        if (!stat.have_free)
                        begin
                            cmd.note_free = 1'b1;
                        end
                        cmd.wr_free     = 1'b1;
                        cmd.inc_count   = 1'b1;
                        cmd.res_success = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else if (stat.rd_status == hklp_pkg::StOccupied && stat.hash_match)
                begin
                    cmd.emit        = 1'b1;
                    cmd.res_success = 1'b1;
                    if (stat.func == hklp_pkg::FuncLookup)
                    begin
                        cmd.res_value = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_hit    = 1'b1;
                        cmd.dec_count = (stat.func == hklp_pkg::FuncDelete);
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    if (stat.rd_status == hklp_pkg::StDeleted && !stat.have_free)
                    begin
                        cmd.note_free = 1'b1;
                    end
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            mul_last_reg <= 1'b0;
            busy         <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            mul_last_reg <= mul_last_next;
            busy         <= (state_next != S_IDLE);
        end
    end

endmodule
